[sv/psc_pkg.sv]
`timescale 1ns / 1ps
// psc_pkg: types, constants, shift table and microprogram of the pressure
// sensor compensation block. No dependencies.
package psc_pkg;

  localparam int RAW_W    = 24;
  localparam int COEF_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int DT_W     = 26;   // stored temperature difference
  localparam int MUL_W    = 30;   // signed multiplier operands
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 64;
  localparam int SENS_W   = 39;
  localparam int OFF_W    = 41;
  localparam int MAG_W    = 28;   // magnitude of psi-scaled pressure
  localparam int QUOT_W   = 14;
  localparam int REM_W    = 14;
  localparam int FRAC_W   = 27;
  localparam int SH_W     = 5;
  localparam int PC_W     = 5;
  localparam int IDX_W    = 3;
  localparam int VAR_W    = 4;

  localparam int SENS_SPLIT    = 20;  // sens split into high and low part for sens * raw
  localparam int PROD_SHIFT    = 21;
  localparam int PSI_SHIFT     = 15;
  localparam int RECIP1_SHIFT  = 42;
  localparam int RECIP2_SHIFT  = 41;

  localparam logic signed [ACC_W-1:0] TEMP_BASE = 64'sd2000;
  localparam logic signed [MUL_W-1:0] PA_NUM    = 30'sd6895;
  localparam logic signed [MUL_W-1:0] PA_DEN    = 30'sd10000;
  // ceil(2^42 / 10000) and ceil(2^41 / 10000): exact floor division for
  // 28-bit and 27-bit dividends
  localparam logic signed [MUL_W-1:0] RECIP1    = 30'sd439804652;
  localparam logic signed [MUL_W-1:0] RECIP2    = 30'sd219902326;

  typedef struct packed {
    logic                      op;
    logic [RAW_W-1:0]          raw_value;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic [COEF_W-1:0]         data;
  } cfg_item_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_VARIANT,
    REG_SENS,
    REG_OFFSET,
    REG_SENS_TC,
    REG_OFFSET_TC,
    REG_REF_TEMP,
    REG_TEMP_SENS
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } coeffs_t;

  typedef struct packed {
    logic [SH_W-1:0] sens_sh;
    logic [SH_W-1:0] off_sh;
    logic [SH_W-1:0] sens_tc_sh;
    logic [SH_W-1:0] off_tc_sh;
    logic [SH_W-1:0] ref_sh;
    logic [SH_W-1:0] temp_sh;
  } shift_row_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_DT,        // dt = raw - (ref << q)
    ALU_TEMP,      // acc = 2000 + (prod >>> q)
    ALU_OFF,       // off = base + (prod >>> q)
    ALU_SENS,      // sens = base + (prod >>> q)
    ALU_ACC_HI,    // acc = prod << 20
    ALU_ACC_ADD,   // acc += prod
    ALU_SUB_OFF,   // acc = (acc >>> 21) - off
    ALU_MAG,       // sign and magnitude of acc >>> 15
    ALU_QUOT,      // quot = prod >> 42
    ALU_REM,       // rem = mag - prod
    ALU_FRAC,      // frac = prod
    ALU_ACC_LOAD,  // acc = prod
    ALU_ACC_FRAC,  // acc += prod >> 41
    ALU_SIGN       // acc = neg ? -acc : acc
  } alu_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DT_C5,
    MUL_DT_C3,
    MUL_DT_C2,
    MUL_SH_RAW,
    MUL_SL_RAW,
    MUL_MAG_R1,
    MUL_QUOT_DEN,
    MUL_REM_NUM,
    MUL_QUOT_NUM,
    MUL_FRAC_R2
  } mul_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_FETCH
  } jmp_t;

  typedef struct packed {
    alu_op_t          alu;
    mul_sel_t         mul;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
    logic             emit;
  } ucode_t;

  // datapath controls for one cycle
  typedef struct packed {
    alu_op_t  alu;
    mul_sel_t mul;
    logic     load_in;
    logic     emit;
  } dp_ctl_t;

  localparam logic [PC_W-1:0] PC_FETCH = 5'd0;
  localparam logic [PC_W-1:0] PC_TEMP  = 5'd1;
  localparam logic [PC_W-1:0] PC_PRES  = 5'd4;

  function automatic shift_row_t shift_row(input logic [VAR_W-1:0] variant);
    shift_row_t r;
    unique case (variant)
      4'd0:    r = '{5'd15, 5'd17, 5'd7, 5'd5, 5'd7, 5'd21};
      4'd1:    r = '{5'd14, 5'd16, 5'd8, 5'd6, 5'd7, 5'd22};
      4'd2:    r = '{5'd16, 5'd18, 5'd6, 5'd4, 5'd7, 5'd22};
      4'd3:    r = '{5'd16, 5'd17, 5'd6, 5'd5, 5'd7, 5'd21};
      4'd4:    r = '{5'd17, 5'd19, 5'd5, 5'd3, 5'd7, 5'd22};
      4'd5:    r = '{5'd16, 5'd17, 5'd6, 5'd5, 5'd7, 5'd22};
      4'd6:    r = '{5'd16, 5'd17, 5'd6, 5'd5, 5'd7, 5'd22};
      4'd7:    r = '{5'd17, 5'd19, 5'd5, 5'd3, 5'd7, 5'd22};
      4'd8:    r = '{5'd17, 5'd18, 5'd5, 5'd4, 5'd7, 5'd22};
      4'd9:    r = '{5'd17, 5'd18, 5'd5, 5'd4, 5'd7, 5'd22};
      // last row, also used for variants above the table
      default: r = '{5'd18, 5'd21, 5'd4, 5'd1, 5'd7, 5'd22};
    endcase
    return r;
  endfunction

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t cw;
    cw.alu    = ALU_NOP;
    cw.mul    = MUL_NONE;
    cw.jmp    = JMP_NEXT;
    cw.target = PC_FETCH;
    cw.emit   = 1'b0;
    unique case (pc)
      PC_FETCH:         cw.jmp = JMP_FETCH;
      // temperature
      PC_TEMP:          cw.alu = ALU_DT;
      PC_TEMP + 5'd1:   cw.mul = MUL_DT_C5;
      PC_TEMP + 5'd2: begin
        cw.alu  = ALU_TEMP;
        cw.emit = 1'b1;
        cw.jmp  = JMP_GOTO;
      end
      // pressure
      PC_PRES:          cw.mul = MUL_DT_C3;
      PC_PRES + 5'd1: begin
        cw.mul = MUL_DT_C2;
        cw.alu = ALU_OFF;
      end
      PC_PRES + 5'd2:   cw.alu = ALU_SENS;
      PC_PRES + 5'd3:   cw.mul = MUL_SH_RAW;
      PC_PRES + 5'd4: begin
        cw.mul = MUL_SL_RAW;
        cw.alu = ALU_ACC_HI;
      end
      PC_PRES + 5'd5:   cw.alu = ALU_ACC_ADD;
      PC_PRES + 5'd6:   cw.alu = ALU_SUB_OFF;
      PC_PRES + 5'd7:   cw.alu = ALU_MAG;
      PC_PRES + 5'd8:   cw.mul = MUL_MAG_R1;
      PC_PRES + 5'd9:   cw.alu = ALU_QUOT;
      PC_PRES + 5'd10:  cw.mul = MUL_QUOT_DEN;
      PC_PRES + 5'd11:  cw.alu = ALU_REM;
      PC_PRES + 5'd12:  cw.mul = MUL_REM_NUM;
      PC_PRES + 5'd13: begin
        cw.mul = MUL_QUOT_NUM;
        cw.alu = ALU_FRAC;
      end
      PC_PRES + 5'd14: begin
        cw.mul = MUL_FRAC_R2;
        cw.alu = ALU_ACC_LOAD;
      end
      PC_PRES + 5'd15:  cw.alu = ALU_ACC_FRAC;
      PC_PRES + 5'd16: begin
        cw.alu  = ALU_SIGN;
        cw.emit = 1'b1;
        cw.jmp  = JMP_GOTO;
      end
      default:          cw.jmp = JMP_GOTO;
    endcase
    return cw;
  endfunction

endpackage

[sv/psc_chan_if.sv]
`timescale 1ns / 1ps
// psc_chan_if: valid/ready channel carrying one payload item.
// Payload type is set by the instantiating level, usually from psc_pkg.
interface psc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/psc_sequencer.sv]
`timescale 1ns / 1ps
// psc_sequencer: step counter, control store lookup and jump logic.
// Depends on psc_pkg for the microprogram and control types.
module psc_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  input  logic              out_free,
  output logic              in_ready,
  output psc_pkg::dp_ctl_t  ctl
);

  logic [psc_pkg::PC_W-1:0] pc;
  logic [psc_pkg::PC_W-1:0] pc_next;
  psc_pkg::ucode_t          cw;
  logic                     stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= psc_pkg::PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    cw       = psc_pkg::ucode(pc);
    in_ready = (cw.jmp == psc_pkg::JMP_FETCH);
    // a result step waits until the output register can take it
    stall    = cw.emit && !out_free;
    pc_next  = pc;
    if (!stall) begin
      unique case (cw.jmp)
        psc_pkg::JMP_NEXT:  pc_next = pc + psc_pkg::PC_W'(1);
        psc_pkg::JMP_GOTO:  pc_next = cw.target;
        psc_pkg::JMP_FETCH: begin
          if (in_valid) begin
            pc_next = in_op ? psc_pkg::PC_PRES : psc_pkg::PC_TEMP;
          end
        end
        default:            pc_next = psc_pkg::PC_FETCH;
      endcase
    end
    ctl.alu     = stall ? psc_pkg::ALU_NOP : cw.alu;
    ctl.mul     = stall ? psc_pkg::MUL_NONE : cw.mul;
    ctl.emit    = cw.emit && !stall;
    ctl.load_in = in_ready && in_valid;
  end

endmodule

[sv/psc_datapath.sv]
`timescale 1ns / 1ps
// psc_datapath: shared 30x30 multiplier, 64-bit accumulator and working
// registers driven by the sequencer's control word. Depends on psc_pkg.
module psc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  psc_pkg::dp_ctl_t                  ctl,
  input  psc_pkg::in_item_t                 item,
  input  psc_pkg::coeffs_t                  coef,
  input  psc_pkg::shift_row_t               sh,
  output logic                              kind,
  output logic signed [psc_pkg::VALUE_W-1:0] value
);

  localparam int ACC_W  = psc_pkg::ACC_W;
  localparam int MUL_W  = psc_pkg::MUL_W;
  localparam int PROD_W = psc_pkg::PROD_W;
  localparam int DT_W   = psc_pkg::DT_W;
  localparam int SENS_W = psc_pkg::SENS_W;
  localparam int OFF_W  = psc_pkg::OFF_W;
  localparam int MAG_W  = psc_pkg::MAG_W;
  localparam int SPLIT  = psc_pkg::SENS_SPLIT;
  localparam int HI_W   = SENS_W - SPLIT;

  logic                         op_q;
  logic [psc_pkg::RAW_W-1:0]    raw_q;
  logic signed [DT_W-1:0]       dt;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      acc_next;
  logic signed [OFF_W-1:0]      off;
  logic signed [SENS_W-1:0]     sens;
  logic                         neg;
  logic [MAG_W-1:0]             mag;
  logic [psc_pkg::QUOT_W-1:0]   quot;
  logic [psc_pkg::REM_W-1:0]    rem;
  logic [psc_pkg::FRAC_W-1:0]   frac;

  logic signed [DT_W-1:0]       dt_calc;
  logic signed [ACC_W-1:0]      prod_x;
  logic signed [ACC_W-1:0]      off_x;
  logic signed [ACC_W-1:0]      off_base;
  logic signed [ACC_W-1:0]      off_term;
  logic signed [ACC_W-1:0]      off_sum;
  logic signed [ACC_W-1:0]      sens_base;
  logic signed [ACC_W-1:0]      sens_term;
  logic signed [ACC_W-1:0]      sens_sum;
  logic signed [ACC_W-1:0]      psi;
  logic signed [ACC_W-1:0]      psi_abs;
  logic [MAG_W-1:0]             rem_calc;

  // operands and partial results
  assign dt_calc   = {2'b00, raw_q} - (DT_W'(coef.ref_temp) << sh.ref_sh);
  assign prod_x    = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
  assign off_x     = {{(ACC_W-OFF_W){off[OFF_W-1]}}, off};
  assign off_base  = $signed(ACC_W'(coef.offset) << sh.off_sh);
  assign off_term  = prod_x >>> sh.off_tc_sh;
  assign off_sum   = off_base + off_term;
  assign sens_base = $signed(ACC_W'(coef.sens) << sh.sens_sh);
  assign sens_term = prod_x >>> sh.sens_tc_sh;
  assign sens_sum  = sens_base + sens_term;
  assign psi       = acc >>> psc_pkg::PSI_SHIFT;
  assign psi_abs   = psi[ACC_W-1] ? -psi : psi;
  assign rem_calc  = mag - mul_p[MAG_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul)
      psc_pkg::MUL_DT_C5: begin
        mul_a = {{(MUL_W-DT_W){dt[DT_W-1]}}, dt};
        mul_b = MUL_W'(coef.temp_sens);
      end
      psc_pkg::MUL_DT_C3: begin
        mul_a = {{(MUL_W-DT_W){dt[DT_W-1]}}, dt};
        mul_b = MUL_W'(coef.offset_tc);
      end
      psc_pkg::MUL_DT_C2: begin
        mul_a = {{(MUL_W-DT_W){dt[DT_W-1]}}, dt};
        mul_b = MUL_W'(coef.sens_tc);
      end
      psc_pkg::MUL_SH_RAW: begin
        mul_a = {{(MUL_W-HI_W){sens[SENS_W-1]}}, sens[SENS_W-1:SPLIT]};
        mul_b = MUL_W'(raw_q);
      end
      psc_pkg::MUL_SL_RAW: begin
        mul_a = MUL_W'(sens[SPLIT-1:0]);
        mul_b = MUL_W'(raw_q);
      end
      psc_pkg::MUL_MAG_R1: begin
        mul_a = MUL_W'(mag);
        mul_b = psc_pkg::RECIP1;
      end
      psc_pkg::MUL_QUOT_DEN: begin
        mul_a = MUL_W'(quot);
        mul_b = psc_pkg::PA_DEN;
      end
      psc_pkg::MUL_REM_NUM: begin
        mul_a = MUL_W'(rem);
        mul_b = psc_pkg::PA_NUM;
      end
      psc_pkg::MUL_QUOT_NUM: begin
        mul_a = MUL_W'(quot);
        mul_b = psc_pkg::PA_NUM;
      end
      psc_pkg::MUL_FRAC_R2: begin
        mul_a = MUL_W'(frac);
        mul_b = psc_pkg::RECIP2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (ctl.alu)
      psc_pkg::ALU_TEMP:     acc_next = (prod_x >>> sh.temp_sh) + psc_pkg::TEMP_BASE;
      psc_pkg::ALU_ACC_HI:   acc_next = prod_x <<< SPLIT;
      psc_pkg::ALU_ACC_ADD:  acc_next = acc + prod_x;
      psc_pkg::ALU_SUB_OFF:  acc_next = (acc >>> psc_pkg::PROD_SHIFT) - off_x;
      psc_pkg::ALU_ACC_LOAD: acc_next = prod_x;
      psc_pkg::ALU_ACC_FRAC: acc_next = acc + (prod_x >>> psc_pkg::RECIP2_SHIFT);
      psc_pkg::ALU_SIGN:     acc_next = neg ? -acc : acc;
      default:               acc_next = acc;
    endcase
  end

  assign kind  = op_q;
  assign value = acc_next[psc_pkg::VALUE_W-1:0];

  // kept temperature difference
  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= '0;
    end else if (ctl.alu == psc_pkg::ALU_DT) begin
      dt <= dt_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      op_q  <= item.op;
      raw_q <= item.raw_value;
    end
    if (ctl.mul != psc_pkg::MUL_NONE) begin
      mul_p <= mul_a * mul_b;
    end
    acc <= acc_next;
    unique case (ctl.alu)
      psc_pkg::ALU_OFF:  off  <= off_sum[OFF_W-1:0];
      psc_pkg::ALU_SENS: sens <= sens_sum[SENS_W-1:0];
      psc_pkg::ALU_MAG: begin
        neg <= psi[ACC_W-1];
        mag <= psi_abs[MAG_W-1:0];
      end
      psc_pkg::ALU_QUOT: quot <= mul_p[psc_pkg::RECIP1_SHIFT +: psc_pkg::QUOT_W];
      psc_pkg::ALU_REM:  rem  <= rem_calc[psc_pkg::REM_W-1:0];
      psc_pkg::ALU_FRAC: frac <= mul_p[psc_pkg::FRAC_W-1:0];
      default: ;
    endcase
  end

endmodule

[sv/pressure_sensor_compensation_top.sv]
`timescale 1ns / 1ps
// pressure_sensor_compensation_top: configuration registers, output register
// and assertions; depends on psc_pkg, psc_chan_if, psc_sequencer, psc_datapath.
//
// Usage:
//   sample: raw conversions (op 0 temperature, op 1 pressure, 24-bit raw_value),
//           taken on a valid/ready transfer.
//   result: one item per sample, kind = op, value = 0.01 degC or Pa (signed).
//   cfg:    register writes (index 0 range variant, 1..6 calibration words),
//           always ready; write only while no sample is in flight.
//   Timing: a microprogram drives one shared 30x30 multiplier, used once per
//   product. A sample's steps run in order up to its result step; the next
//   sample is taken only after that step, so one sample is in work at a time.
//   Stall: the result waits in the output register; the next sample is still
//   taken and processed, holding at its last step until the register frees.
//   Reset: calibration words, range variant and the kept temperature
//   difference clear to zero; the output register empties.
module pressure_sensor_compensation_top (
  input  logic        clk,
  input  logic        rst,
  psc_chan_if.sink    sample,
  psc_chan_if.sink    cfg,
  psc_chan_if.source  result
);

  logic [psc_pkg::VAR_W-1:0]          range_variant;
  psc_pkg::coeffs_t                    coef;
  psc_pkg::shift_row_t                 sh;
  psc_pkg::dp_ctl_t                    ctl;
  psc_pkg::out_item_t                  out_item;
  logic                                out_valid;
  logic                                out_free;
  logic                                dp_kind;
  logic signed [psc_pkg::VALUE_W-1:0]  dp_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_variant <= '0;
      coef          <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        psc_pkg::REG_RANGE_VARIANT: range_variant <= cfg.payload.data[psc_pkg::VAR_W-1:0];
        psc_pkg::REG_SENS:          coef.sens      <= cfg.payload.data;
        psc_pkg::REG_OFFSET:        coef.offset    <= cfg.payload.data;
        psc_pkg::REG_SENS_TC:       coef.sens_tc   <= cfg.payload.data;
        psc_pkg::REG_OFFSET_TC:     coef.offset_tc <= cfg.payload.data;
        psc_pkg::REG_REF_TEMP:      coef.ref_temp  <= cfg.payload.data;
        psc_pkg::REG_TEMP_SENS:     coef.temp_sens <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  assign sh       = psc_pkg::shift_row(range_variant);
  assign out_free = !out_valid || result.ready;

  psc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_op    (sample.payload.op),
    .out_free (out_free),
    .in_ready (sample.ready),
    .ctl      (ctl)
  );

  psc_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .item  (sample.payload),
    .coef  (coef),
    .sh    (sh),
    .kind  (dp_kind),
    .value (dp_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_item.kind  <= dp_kind;
      out_item.value <= dp_value;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

`ifndef SYNTH
  // a new result never overwrites one that has not been transferred
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || result.ready))
    else $error("result written over a pending one");

  // no sample produces its result in the cycle right after its transfer
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !ctl.emit)
    else $error("result emitted one cycle after sample transfer");

  // while waiting for a sample the datapath stays quiet
  a_fetch_quiet: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> (!ctl.emit && ctl.alu == psc_pkg::ALU_NOP))
    else $error("datapath active while waiting for a sample");
`endif

endmodule

[tb/pressure_sensor_compensation_top_test.sv]
`timescale 1ns / 1ps
// pressure_sensor_compensation_top_test: self-checking bench for the pressure sensor
// compensation block, a directed table then random phases checked by a predictor;
// depends on psc_pkg, psc_chan_if and pressure_sensor_compensation_top.
module pressure_sensor_compensation_top_test;
  import psc_pkg::*;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int MAX_VARIANT = 10;
  localparam int SH_SENS     = 0;
  localparam int SH_OFF      = 1;
  localparam int SH_SENS_TC  = 2;
  localparam int SH_OFF_TC   = 3;
  localparam int SH_REF      = 4;
  localparam int SH_TEMP     = 5;
  localparam int unsigned SHIFT_TAB [0:10][0:5] = '{
    '{15, 17, 7, 5, 7, 21},
    '{14, 16, 8, 6, 7, 22},
    '{16, 18, 6, 4, 7, 22},
    '{16, 17, 6, 5, 7, 21},
    '{17, 19, 5, 3, 7, 22},
    '{16, 17, 6, 5, 7, 22},
    '{16, 17, 6, 5, 7, 22},
    '{17, 19, 5, 3, 7, 22},
    '{17, 18, 5, 4, 7, 22},
    '{17, 18, 5, 4, 7, 22},
    '{18, 21, 4, 1, 7, 22}
  };
  localparam longint TEMP_ZERO   = 2000;
  localparam longint PA_PER_NUM  = 6895;
  localparam longint PA_PER_DEN  = 10000;
  localparam int     PROD_DROP   = 21;
  localparam int     PSI_DROP    = 15;

  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 70;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 40;

  typedef struct packed {
    logic                      is_write;
    logic [IDX_W-1:0]          index;
    logic [COEF_W-1:0]         data;
    logic                      op;
    logic [RAW_W-1:0]          raw;
    logic                      pinned;
    logic signed [VALUE_W-1:0] pinned_value;
  } step_t;

  localparam int DIR_STEPS = 43;

  // pinned values only where the result is obvious (all calibration words zero)
  step_t directed_steps [0:DIR_STEPS-1] = '{
    // reset defaults, pressure before any temperature
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'hFFFFFF, 1'b1, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h000000, 1'b1, 32'sd0},
    // typical calibration, difference still zero
    '{1'b1, REG_RANGE_VARIANT, 16'd0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS,          16'd36963, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET,        16'd35305, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS_TC,       16'd22453, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET_TC,     16'd22343, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_REF_TEMP,      16'd30533, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_TEMP_SENS,     16'd28184, OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h800000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'h3C0000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h600000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'hFFFFFF, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'h000000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h000000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'hFFFFFF, 1'b0, 32'sd0},
    // every word at its maximum, last table row
    '{1'b1, REG_RANGE_VARIANT, 16'd10,    OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS,          16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET,        16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS_TC,       16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET_TC,     16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_REF_TEMP,      16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_TEMP_SENS,     16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'h000000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'hFFFFFF, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h000000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'hFFFFFF, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'hFFFFFF, 1'b0, 32'sd0},
    // variant above the table saturates, write to an unused index is dropped
    '{1'b1, REG_RANGE_VARIANT, 16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_UNUSED,        16'hFFFF,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'h800000, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h800000, 1'b0, 32'sd0},
    '{1'b1, REG_RANGE_VARIANT, 16'd11,    OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h7FFFFF, 1'b0, 32'sd0},
    // all words zero: temperature sits at its base, pressure at zero
    '{1'b1, REG_RANGE_VARIANT, 16'hFFF4,  OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS,          16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET,        16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_SENS_TC,       16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_OFFSET_TC,     16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_REF_TEMP,      16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b1, REG_TEMP_SENS,     16'h0,     OP_TEMP, 24'h0, 1'b0, 32'sd0},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_TEMP, 24'hABCDEF, 1'b1, 32'sd2000},
    '{1'b0, REG_RANGE_VARIANT, 16'h0, OP_PRES, 24'h123456, 1'b1, 32'sd0}
  };

  logic clk;
  logic rst;

  psc_chan_if #(.payload_t(in_item_t))  sample_ch ();
  psc_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();
  psc_chan_if #(.payload_t(out_item_t)) result_ch ();

  pressure_sensor_compensation_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  // predictor state
  logic [VAR_W-1:0]  range_sel;
  logic [COEF_W-1:0] cal_word [1:6];
  int                kept_dt;

  out_item_t pending_readings [$];
  int        mismatch_count;

  logic                      pin_en;
  logic signed [VALUE_W-1:0] pin_value;
  bit                        offering;
  bit                        cfg_open;
  bit                        idle_off;
  int                        hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic out_item_t compensate(input in_item_t conv);
    out_item_t res;
    int        row;
    longint    raw, dt, offs, sens, psi, acc;
    row = (range_sel > MAX_VARIANT) ? MAX_VARIANT : int'(range_sel);
    raw = longint'(conv.raw_value);
    res.kind = conv.op;
    if (conv.op == OP_TEMP) begin
      dt = raw - (longint'(cal_word[REG_REF_TEMP]) << SHIFT_TAB[row][SH_REF]);
      kept_dt = int'(dt);
      acc = TEMP_ZERO
          + ((dt * longint'(cal_word[REG_TEMP_SENS])) >>> SHIFT_TAB[row][SH_TEMP]);
    end else begin
      dt = longint'(kept_dt);
      offs = (longint'(cal_word[REG_OFFSET]) << SHIFT_TAB[row][SH_OFF])
           + ((longint'(cal_word[REG_OFFSET_TC]) * dt) >>> SHIFT_TAB[row][SH_OFF_TC]);
      sens = (longint'(cal_word[REG_SENS]) << SHIFT_TAB[row][SH_SENS])
           + ((longint'(cal_word[REG_SENS_TC]) * dt) >>> SHIFT_TAB[row][SH_SENS_TC]);
      psi = (((sens * raw) >>> PROD_DROP) - offs) >>> PSI_DROP;
      // signed division truncates toward zero
      acc = (psi * PA_PER_NUM) / PA_PER_DEN;
    end
    res.value = 32'(acc);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // transfers seen at the rising edge: results first, then new expectations
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d value %0d",
                                  result_ch.payload.kind, result_ch.payload.value));
        end else begin
          want = pending_readings.pop_front();
          if (result_ch.payload.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, want %0d",
                                    result_ch.payload.kind, want.kind));
          if (result_ch.payload.value !== want.value)
            note_mismatch($sformatf("value %0d, want %0d (kind %0d)",
                                    result_ch.payload.value, want.value, want.kind));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.payload.index == REG_RANGE_VARIANT)
          range_sel = cfg_ch.payload.data[VAR_W-1:0];
        else if (cfg_ch.payload.index <= REG_TEMP_SENS)
          cal_word[cfg_ch.payload.index] = cfg_ch.payload.data;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        want = compensate(sample_ch.payload);
        if (pin_en)
          want.value = pin_value;
        pending_readings.push_back(want);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, plus a long hold-off when asked
  initial begin : result_taker
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = pick_gap();
      end
      repeat (stall) begin
        result_ch.ready <= 1'b0;
        @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // drop both valids and wait until every result has been taken
  task automatic go_idle();
    if (offering) begin
      sample_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    do @(negedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    if (!cfg_open)
      go_idle();
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= {idx, data};
    cfg_open = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_conv(input logic op, input logic [RAW_W-1:0] raw,
                           input logic pinned, input logic signed [VALUE_W-1:0] pval);
    int gap;
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = pick_gap();
    if (gap > 0) begin
      if (offering)
        sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= {op, raw};
    pin_en            <= pinned;
    pin_value         <= pval;
    offering = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic             op;
    logic [RAW_W-1:0] raw;
    logic [COEF_W-1:0] word;
    range_sel = '0;
    foreach (cal_word[i])
      cal_word[i] = '0;
    kept_dt = 0;
    mismatch_count = 0;
    offering = 1'b0;
    cfg_open = 1'b0;
    idle_off = 1'b0;
    hold_off_cycles = 0;
    pin_en = 1'b0;
    pin_value = '0;
    sample_ch.valid = 1'b0;
    sample_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write)
        write_reg(directed_steps[i].index, directed_steps[i].data);
      else
        send_conv(directed_steps[i].op, directed_steps[i].raw,
                  directed_steps[i].pinned, directed_steps[i].pinned_value);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // a full calibration set per phase, extremes in two of them
      idle_off = 1'b0;
      word = (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0000 : 16'($urandom);
      write_reg(REG_RANGE_VARIANT, word);
      for (int r = REG_SENS; r <= REG_TEMP_SENS; r++) begin
        word = (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0000 : 16'($urandom);
        write_reg(r[IDX_W-1:0], word);
      end
      if (phase == 5)
        write_reg(REG_UNUSED, 16'($urandom));
      idle_off = (phase == 3);
      if (phase == 4 || phase == 6)
        hold_off_cycles = HOLD_OFF_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // a random mix: a temperature with 30 percent chance, else a pressure
        op = ($urandom_range(0, 99) < 30) ? OP_TEMP : OP_PRES;
        case ($urandom_range(0, 9))
          0:       raw = '0;
          1:       raw = '1;
          2, 3:    raw = RAW_W'(int'(cal_word[REG_REF_TEMP]) * 128
                                + $urandom_range(0, 1 << 20) - (1 << 19));
          default: raw = RAW_W'($urandom);
        endcase
        if (phase == 7 && n == PHASE_ITEMS / 2)
          go_idle();
        send_conv(op, raw, 1'b0, '0);
      end
    end

    go_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
sv/psc_pkg.sv
sv/psc_chan_if.sv
sv/psc_sequencer.sv
sv/psc_datapath.sv
sv/pressure_sensor_compensation_top.sv
tb/pressure_sensor_compensation_top_test.sv
